### design/vt4_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vt4_pkg: shared types and constants for the 4x4 vertex transform
// Fixed-point formats, matrix register codes, result layout and buffer sizes.
// ----------------------------------------------------------------------------
package vt4_pkg;

  // Q16.16 element format
  localparam int XW       = 32;
  localparam int FRAC     = 16;
  localparam int NUM_ROWS = 4;
  localparam int NUM_COLS = 4;

  // Matrix configuration registers: two per row, two elements per register
  localparam int NUM_REGS  = 8;
  localparam int CFG_IDX_W = $clog2(NUM_REGS);
  localparam int CFG_DW    = 2 * XW;

  // Lane arithmetic widths
  localparam int PROD_W = 2 * XW;          // exact Q32.32 product
  localparam int PAIR_W = PROD_W + 1;      // sum of two products
  localparam int SUM_W  = PROD_W + 2;      // sum of four products
  localparam int RND_W  = SUM_W - FRAC;    // rounded sum before clamping

  // Pipeline depth of a lane, and of lanes plus merge register
  localparam int LANE_LAT = 3;
  localparam int PIPE_LAT = LANE_LAT + 1;

  // Output buffer: deep enough to cover every beat in flight
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [XW-1:0] ONE_Q16 = XW'(1) << FRAC;
  localparam logic signed [XW-1:0] SAT_MAX = {1'b0, {(XW-1){1'b1}}};
  localparam logic signed [XW-1:0] SAT_MIN = {1'b1, {(XW-1){1'b0}}};

  typedef logic signed [XW-1:0] fix_t;
  typedef fix_t [NUM_COLS-1:0] fix_vec_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW0_COLS01 = 3'd0,
    REG_ROW0_COLS23 = 3'd1,
    REG_ROW1_COLS01 = 3'd2,
    REG_ROW1_COLS23 = 3'd3,
    REG_ROW2_COLS01 = 3'd4,
    REG_ROW2_COLS23 = 3'd5,
    REG_ROW3_COLS01 = 3'd6,
    REG_ROW3_COLS23 = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    fix_t x;
    fix_t y;
    fix_t z;
    fix_t w;
    logic saturated;
  } result_t;

  // Identity matrix: 1.0 on the diagonal
  function automatic logic [CFG_DW-1:0] mat_reset_val(cfg_reg_t idx);
    logic [CFG_DW-1:0] val;
    unique case (idx)
      REG_ROW0_COLS01: val = {{XW{1'b0}}, ONE_Q16};
      REG_ROW1_COLS01: val = {ONE_Q16, {XW{1'b0}}};
      REG_ROW2_COLS23: val = {{XW{1'b0}}, ONE_Q16};
      REG_ROW3_COLS23: val = {ONE_Q16, {XW{1'b0}}};
      default:         val = '0;
    endcase
    return val;
  endfunction

endpackage

### design/vt4_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vt4_if: stream interfaces of the vertex transform
// Vertex input channel and transformed result channel, valid/ready beats.
// ----------------------------------------------------------------------------
interface vt4_in_if;
  logic         valid;
  logic         ready;
  vt4_pkg::fix_t in_x;
  vt4_pkg::fix_t in_y;
  vt4_pkg::fix_t in_z;
  vt4_pkg::fix_t in_w;

  modport source (output valid, output in_x, output in_y, output in_z, output in_w,
                  input ready);
  modport sink   (input valid, input in_x, input in_y, input in_z, input in_w,
                  output ready);
endinterface

interface vt4_out_if;
  logic          valid;
  logic          ready;
  vt4_pkg::fix_t out_x;
  vt4_pkg::fix_t out_y;
  vt4_pkg::fix_t out_z;
  vt4_pkg::fix_t out_w;
  logic          saturated;

  modport source (output valid, output out_x, output out_y, output out_z, output out_w,
                  output saturated, input ready);
  modport sink   (input valid, input out_x, input out_y, input out_z, input out_w,
                  input saturated, output ready);
endinterface

### design/vt4_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vt4_lane: one matrix row dot product
// Four exact products, a two-level adder tree, round half up and clamp.
// ----------------------------------------------------------------------------
module vt4_lane (
  input  logic              clk,
  input  vt4_pkg::fix_vec_t row_elem,
  input  vt4_pkg::fix_vec_t vtx,
  output vt4_pkg::fix_t     res_r,
  output logic              sat_r
);

  logic signed [vt4_pkg::PROD_W-1:0] prod_r [vt4_pkg::NUM_COLS];
  logic signed [vt4_pkg::PAIR_W-1:0] s01_r;
  logic signed [vt4_pkg::PAIR_W-1:0] s23_r;
  logic signed [vt4_pkg::SUM_W-1:0]  sum;
  logic signed [vt4_pkg::RND_W-1:0]  rnd;
  logic                              over_hi;
  logic                              over_lo;
  vt4_pkg::fix_t                     res_nxt;

  // Stage 1: exact Q32.32 products
  always_ff @(posedge clk) begin
    for (int c = 0; c < vt4_pkg::NUM_COLS; c++) begin
      prod_r[c] <= $signed(row_elem[c]) * $signed(vtx[c]);
    end
  end

  // Stage 2: pairwise sums
  always_ff @(posedge clk) begin
    s01_r <= vt4_pkg::PAIR_W'(prod_r[0]) + vt4_pkg::PAIR_W'(prod_r[1]);
    s23_r <= vt4_pkg::PAIR_W'(prod_r[2]) + vt4_pkg::PAIR_W'(prod_r[3]);
  end

  // Stage 3: final sum plus half an LSB, drop fraction, clamp to 32 bits
  always_comb begin
    sum = vt4_pkg::SUM_W'(s01_r) + vt4_pkg::SUM_W'(s23_r)
        + (vt4_pkg::SUM_W'(1) <<< (vt4_pkg::FRAC - 1));
    rnd = sum[vt4_pkg::SUM_W-1:vt4_pkg::FRAC];
    over_hi = !rnd[vt4_pkg::RND_W-1] && (|rnd[vt4_pkg::RND_W-2:vt4_pkg::XW-1]);
    over_lo = rnd[vt4_pkg::RND_W-1] && !(&rnd[vt4_pkg::RND_W-2:vt4_pkg::XW-1]);
    priority if (over_hi) begin
      res_nxt = vt4_pkg::SAT_MAX;
    end else if (over_lo) begin
      res_nxt = vt4_pkg::SAT_MIN;
    end else begin
      res_nxt = rnd[vt4_pkg::XW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    sat_r <= over_hi | over_lo;
  end

endmodule

### design/vt4_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vt4_merge: combine the lane results into one result beat
// Packs the four row results and ORs their clamp flags.
// ----------------------------------------------------------------------------
module vt4_merge (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                lane_valid,
  input  vt4_pkg::fix_vec_t   lane_res,
  input  logic [vt4_pkg::NUM_ROWS-1:0] lane_sat,
  output logic                valid_r,
  output vt4_pkg::result_t    result_r
);

  vt4_pkg::result_t result_nxt;

  always_comb begin
    result_nxt.x         = lane_res[0];
    result_nxt.y         = lane_res[1];
    result_nxt.z         = lane_res[2];
    result_nxt.w         = lane_res[3];
    result_nxt.saturated = |lane_sat;
  end

  // Register the beat; payload needs no reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= lane_valid;
    end
  end

  always_ff @(posedge clk) begin
    result_r <= result_nxt;
  end

endmodule

### design/vt4_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vt4_out_fifo: result buffer with credit accounting
// Holds finished beats and reserves a slot for every beat still in the lanes,
// so the pipeline never has to stall.
// ----------------------------------------------------------------------------
module vt4_out_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             reserve,
  input  logic             push,
  input  vt4_pkg::result_t push_data,
  output logic             room,
  vt4_out_if.source        out_ch
);

  vt4_pkg::result_t               mem_r [vt4_pkg::FIFO_DEPTH];
  logic [vt4_pkg::FIFO_AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [vt4_pkg::FIFO_AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [vt4_pkg::FIFO_AW:0]      fill_r, fill_nxt;
  logic [vt4_pkg::FIFO_AW:0]      credit_r, credit_nxt;
  logic                           pop;
  vt4_pkg::result_t               head;

  assign pop  = out_ch.valid && out_ch.ready;
  assign room = (credit_r < (vt4_pkg::FIFO_AW + 1)'(vt4_pkg::FIFO_DEPTH));

  // Advance pointers and counts
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    unique case ({push, pop})
      2'b10:   fill_nxt = fill_r + 1'b1;
      2'b01:   fill_nxt = fill_r - 1'b1;
      default: fill_nxt = fill_r;
    endcase
    unique case ({reserve, pop})
      2'b10:   credit_nxt = credit_r + 1'b1;
      2'b01:   credit_nxt = credit_r - 1'b1;
      default: credit_nxt = credit_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
      credit_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
      credit_r <= credit_nxt;
    end
  end

  // Store the incoming beat
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Present the oldest beat
  assign head             = mem_r[rd_ptr_r];
  assign out_ch.valid     = (fill_r != '0);
  assign out_ch.out_x     = head.x;
  assign out_ch.out_y     = head.y;
  assign out_ch.out_z     = head.z;
  assign out_ch.out_w     = head.w;
  assign out_ch.saturated = head.saturated;

  // A reserved slot always exists for every arriving beat
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (fill_r != (vt4_pkg::FIFO_AW + 1)'(vt4_pkg::FIFO_DEPTH)))
    else $error("result pushed into a full buffer");

  a_credit_covers_fill: assert property (@(posedge clk) disable iff (!rst_n)
    credit_r >= fill_r)
    else $error("stored beats exceed reserved slots");

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    credit_r <= (vt4_pkg::FIFO_AW + 1)'(vt4_pkg::FIFO_DEPTH))
    else $error("credit count beyond buffer depth");

endmodule

### design/vertex_transform_4x4.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_transform_4x4: 4x4 matrix times homogeneous vertex, Q16.16
// Pipeline: products load at the accepting edge, then pair add,
//   final add/round/clamp, merge register and output buffer write.
// Throughput: one vertex per cycle while the output buffer has credit left,
//   set by the four row lanes working in parallel; an 8-entry output buffer with credits absorbs output stalls.
// Reset: matrix returns to identity, buffer and pipeline empty; no clearing pass.
// ----------------------------------------------------------------------------
module vertex_transform_4x4 (
  input  logic                            clk,
  input  logic                            rst_n,
  vt4_in_if.sink                          in_ch,
  vt4_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [vt4_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [vt4_pkg::CFG_DW-1:0]      cfg_wdata
);

  logic [vt4_pkg::CFG_DW-1:0]     mat_r [vt4_pkg::NUM_REGS];
  logic [vt4_pkg::LANE_LAT-1:0]   vld_r, vld_nxt;
  logic                           accept;
  logic                           room;
  vt4_pkg::fix_vec_t              vtx;
  vt4_pkg::fix_vec_t              lane_res;
  logic [vt4_pkg::NUM_ROWS-1:0]   lane_sat;
  logic                           merge_valid;
  vt4_pkg::result_t               merge_result;

  // Matrix registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < vt4_pkg::NUM_REGS; i++) begin
        mat_r[i] <= vt4_pkg::mat_reset_val(
                      vt4_pkg::cfg_reg_t'(vt4_pkg::CFG_IDX_W'(i)));
      end
    end else if (cfg_we) begin
      mat_r[cfg_index] <= cfg_wdata;
    end
  end

  // Input handshake
  assign in_ch.ready = room && rst_n;
  assign accept      = in_ch.valid && in_ch.ready;
  assign vtx         = {in_ch.in_w, in_ch.in_z, in_ch.in_y, in_ch.in_x};

  // Track beats through the lanes
  assign vld_nxt = {vld_r[vt4_pkg::LANE_LAT-2:0], accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // One lane per matrix row
  for (genvar r = 0; r < vt4_pkg::NUM_ROWS; r++) begin : g_lane
    vt4_pkg::fix_vec_t row_elem;

    assign row_elem = {mat_r[2*r+1][vt4_pkg::CFG_DW-1:vt4_pkg::XW],
                       mat_r[2*r+1][vt4_pkg::XW-1:0],
                       mat_r[2*r][vt4_pkg::CFG_DW-1:vt4_pkg::XW],
                       mat_r[2*r][vt4_pkg::XW-1:0]};

    vt4_lane u_lane (
      .clk      (clk),
      .row_elem (row_elem),
      .vtx      (vtx),
      .res_r    (lane_res[r]),
      .sat_r    (lane_sat[r])
    );
  end

  vt4_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .lane_valid (vld_r[vt4_pkg::LANE_LAT-1]),
    .lane_res   (lane_res),
    .lane_sat   (lane_sat),
    .valid_r    (merge_valid),
    .result_r   (merge_result)
  );

  vt4_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .reserve   (accept),
    .push      (merge_valid),
    .push_data (merge_result),
    .room      (room),
    .out_ch    (out_ch)
  );

  // Every accepted beat reaches the buffer after the full pipeline depth
  a_beat_arrives: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##(vt4_pkg::PIPE_LAT) merge_valid)
    else $error("accepted beat did not reach the output buffer");

endmodule
